>>> hdl/parlt_pkg.sv
// Shared types, codes and constants of the per-address rate limit table.
package parlt_pkg;

	localparam int TABLE_DEPTH_DEF = 128;

	localparam int FAM_W   = 2;
	localparam int HALF_W  = 64;
	localparam int TIME_W  = 32;
	localparam int WIN_W   = 16;
	localparam int MAX_W   = 8;
	localparam int CNT_W   = 9;
	localparam int SLOT_W  = 7;
	localparam int VERD_W  = 3;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 16;

	localparam logic [FAM_W-1:0] FAM_V4  = 2'd0;
	localparam logic [FAM_W-1:0] FAM_V6  = 2'd1;
	localparam logic [FAM_W-1:0] FAM_UNK = 2'd2;

	localparam logic [VERD_W-1:0] VERDICT_ALLOW  = 3'd0;
	localparam logic [VERD_W-1:0] VERDICT_BANNED = 3'd1;
	localparam logic [VERD_W-1:0] VERDICT_FULL   = 3'd2;
	localparam logic [VERD_W-1:0] VERDICT_RATE   = 3'd3;
	localparam logic [VERD_W-1:0] VERDICT_SUSP   = 3'd4;

	localparam logic [CFG_IW-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_MAX    = 2'd1;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd15;
	localparam logic [MAX_W-1:0] MAX_RESET    = 8'd50;
	localparam logic [CNT_W-1:0] CNT_SAT      = 9'h1FF;

	// one table row
	typedef struct packed {
		logic [FAM_W-1:0]  fam;
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
		logic [CNT_W-1:0]  count;
		logic [TIME_W-1:0] start;
		logic              banned;
	} row_t;

	typedef struct packed {
		logic load;     // take a request beat into the request registers
		logic scan_rd;  // read the row at the scan pointer
		logic capture;  // keep the matching row
		logic commit;   // write back and load the result register
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic more;     // rows left to read
		logic scan_end; // nothing left in flight, no match
		logic out_free;
	} status_t;

endpackage

>>> hdl/parlt_ctrl.sv
// Sequencer: request intake, table scan and commit of one request at a time.
module parlt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  parlt_pkg::status_t  st,
	output parlt_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = !st.hit && st.more;
				if (st.hit) begin
					cmd.capture = 1'b1;
					state_d     = ST_UPD;
				end else if (st.scan_end) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				// hold here while the previous result is still not taken
				if (st.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/parlt_dp.sv
// Datapath: request registers, entry table memory, window and ban update, result register.
module parlt_dp #(
	parameter int TABLE_DEPTH = parlt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [parlt_pkg::CFG_IW-1:0]        cfg_index,
	input  logic [parlt_pkg::CFG_DW-1:0]        cfg_data,
	input  logic [parlt_pkg::FAM_W-1:0]         addr_family,
	input  logic [parlt_pkg::HALF_W-1:0]        addr_high,
	input  logic [parlt_pkg::HALF_W-1:0]        addr_low,
	input  logic [parlt_pkg::TIME_W-1:0]        now_seconds,
	input  logic                                suspicious,
	input  parlt_pkg::cmd_t                     cmd,
	output parlt_pkg::status_t                  st,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [parlt_pkg::VERD_W-1:0]        verdict,
	output logic [parlt_pkg::CNT_W-1:0]         request_count,
	output logic [parlt_pkg::SLOT_W-1:0]        entry_index
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// configuration
	logic [parlt_pkg::WIN_W-1:0] win_q;
	logic [parlt_pkg::MAX_W-1:0] max_q;

	// request
	logic [parlt_pkg::FAM_W-1:0]  req_fam_q;
	logic [parlt_pkg::HALF_W-1:0] req_hi_q;
	logic [parlt_pkg::HALF_W-1:0] req_lo_q;
	logic [parlt_pkg::TIME_W-1:0] req_now_q;
	logic                         req_susp_q;
	logic [parlt_pkg::FAM_W-1:0]  norm_fam;
	logic [parlt_pkg::HALF_W-1:0] norm_hi;
	logic [parlt_pkg::HALF_W-1:0] norm_lo;

	// table and scan
	parlt_pkg::row_t mem [TABLE_DEPTH];
	logic [CW-1:0]   used_q;
	logic [CW-1:0]   scan_q;
	parlt_pkg::row_t rd_row_s1;
	logic [IW-1:0]   rd_idx_s1;
	logic            rd_vld_s1;
	parlt_pkg::row_t ent_row_q;
	logic [IW-1:0]   ent_idx_q;
	logic            ent_found_q;

	// update
	logic                          full;
	logic [IW-1:0]                 slot;
	parlt_pkg::row_t               base;
	parlt_pkg::row_t               new_row;
	logic [parlt_pkg::TIME_W-1:0]  age;
	logic                          restart;
	logic [parlt_pkg::CNT_W-1:0]   cnt0;
	logic [parlt_pkg::CNT_W-1:0]   cnt1;
	logic                          over;
	logic                          tbl_we;
	logic [parlt_pkg::VERD_W-1:0]  verdict_d;
	logic [parlt_pkg::CNT_W-1:0]   count_d;

	logic                          out_valid_q;
	logic [parlt_pkg::VERD_W-1:0]  verdict_q;
	logic [parlt_pkg::CNT_W-1:0]   count_q;
	logic [parlt_pkg::SLOT_W-1:0]  index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= parlt_pkg::WINDOW_RESET;
			max_q <= parlt_pkg::MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				parlt_pkg::CFG_WINDOW: win_q <= cfg_data;
				parlt_pkg::CFG_MAX:    max_q <= cfg_data[parlt_pkg::MAX_W-1:0];
				default: ;
			endcase
		end
	end

	// key normalization: IPv4 keeps 32 bits, anything but v4/v6 is one shared key
	always_comb begin
		norm_fam = addr_family;
		norm_hi  = addr_high;
		norm_lo  = addr_low;
		case (addr_family)
			parlt_pkg::FAM_V4: begin
				norm_hi = '0;
				norm_lo = {32'd0, addr_low[31:0]};
			end
			parlt_pkg::FAM_V6: ;
			default: begin
				norm_fam = parlt_pkg::FAM_UNK;
				norm_hi  = '0;
				norm_lo  = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_fam_q  <= norm_fam;
			req_hi_q   <= norm_hi;
			req_lo_q   <= norm_lo;
			req_now_q  <= now_seconds;
			req_susp_q <= suspicious;
		end
	end

	assign st.hit = rd_vld_s1 && (rd_row_s1.fam == req_fam_q)
		&& (rd_row_s1.hi == req_hi_q) && (rd_row_s1.lo == req_lo_q);
	assign st.more     = (scan_q < used_q);
	assign st.scan_end = !rd_vld_s1 && !st.more;
	assign st.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			ent_found_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				scan_q      <= '0;
				ent_found_q <= 1'b0;
			end else if (cmd.scan_rd) begin
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.capture) begin
				ent_found_q <= 1'b1;
			end
			if (cmd.commit && !ent_found_q && !full) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			mem[slot] <= new_row;
		end
		if (cmd.scan_rd) begin
			rd_row_s1 <= mem[scan_q[IW-1:0]];
			rd_idx_s1 <= scan_q[IW-1:0];
		end
		if (cmd.capture) begin
			ent_row_q <= rd_row_s1;
			ent_idx_q <= rd_idx_s1;
		end
	end

	always_comb begin
		full = !ent_found_q && (used_q >= DEPTH_C);
		slot = ent_found_q ? ent_idx_q : used_q[IW-1:0];
		if (ent_found_q) begin
			base = ent_row_q;
		end else begin
			base.fam    = req_fam_q;
			base.hi     = req_hi_q;
			base.lo     = req_lo_q;
			base.count  = '0;
			base.start  = req_now_q;
			base.banned = 1'b0;
		end
		age     = req_now_q - base.start;
		restart = age > {16'd0, win_q};
		cnt0    = restart ? '0 : base.count;
		cnt1    = (cnt0 != parlt_pkg::CNT_SAT) ? cnt0 + 1'b1 : cnt0;
		over    = cnt1 > {1'b0, max_q};

		new_row        = base;
		new_row.count  = cnt1;
		new_row.start  = restart ? req_now_q : base.start;
		new_row.banned = over || req_susp_q;

		tbl_we = cmd.commit && !full && !base.banned;

		if (full) begin
			verdict_d = parlt_pkg::VERDICT_FULL;
			count_d   = '0;
		end else if (base.banned) begin
			verdict_d = parlt_pkg::VERDICT_BANNED;
			count_d   = base.count;
		end else if (over) begin
			verdict_d = parlt_pkg::VERDICT_RATE;
			count_d   = cnt1;
		end else if (req_susp_q) begin
			verdict_d = parlt_pkg::VERDICT_SUSP;
			count_d   = cnt1;
		end else begin
			verdict_d = parlt_pkg::VERDICT_ALLOW;
			count_d   = cnt1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_q <= verdict_d;
			count_q   <= count_d;
			index_q   <= full ? '0 : parlt_pkg::SLOT_W'(slot);
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign request_count = count_q;
	assign entry_index   = index_q;

endmodule

>>> hdl/per_address_rate_limit_table_unit.sv
// Per-address rate limit table: top level with controller, datapath and checks.
//
// Request beats enter on in_valid/in_ready with the client address, the time
// in seconds and the suspicious flag; one verdict beat leaves on
// out_valid/out_ready per request. Registers are written through
// cfg_we/cfg_index/cfg_data (0: window seconds, 1: max requests).
// One request is handled at a time. The time from acceptance to out_valid
// grows with n, the number of table rows read: the matching row's
// position plus one. A new address reads all used rows and also waits
// for the last read to drain. The scan of the single-port entry memory
// is linear, one row per cycle, so the worst case is a new address with
// all TABLE_DEPTH rows in use.
// The next request can be taken as soon as the result is loaded.
// in_ready is high whenever no request is in flight, also while a result
// waits in the output register; a stalled receiver holds the next request
// just before its commit until the output register frees up.
// Reset empties the table (used count zero, no clearing pass) and restores
// the window to 15 seconds and the limit to 50 requests.
module per_address_rate_limit_table_unit #(
	parameter int TABLE_DEPTH = parlt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [parlt_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [parlt_pkg::CFG_DW-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [parlt_pkg::FAM_W-1:0]    addr_family,
	input  logic [parlt_pkg::HALF_W-1:0]   addr_high,
	input  logic [parlt_pkg::HALF_W-1:0]   addr_low,
	input  logic [parlt_pkg::TIME_W-1:0]   now_seconds,
	input  logic                           suspicious,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [parlt_pkg::VERD_W-1:0]   verdict,
	output logic [parlt_pkg::CNT_W-1:0]    request_count,
	output logic [parlt_pkg::SLOT_W-1:0]   entry_index
);

	parlt_pkg::cmd_t    cmd;
	parlt_pkg::status_t st;

	parlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	parlt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.addr_family   (addr_family),
		.addr_high     (addr_high),
		.addr_low      (addr_low),
		.now_seconds   (now_seconds),
		.suspicious    (suspicious),
		.cmd           (cmd),
		.st            (st),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.verdict       (verdict),
		.request_count (request_count),
		.entry_index   (entry_index)
	);

	// one request in flight: no new beat right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// commit never overwrites a result that is still waiting
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> st.out_free)
		else $error("result register overwritten");

	// a table-full verdict carries no count and no slot
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (verdict == parlt_pkg::VERDICT_FULL)
		|-> (request_count == '0) && (entry_index == '0))
		else $error("table-full result with nonzero fields");

	// scan reads and a match capture never overlap
	a_scan_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !cmd.scan_rd && !cmd.commit)
		else $error("scan read during capture");

endmodule
